/* hdl/hab_pkg.sv */
package hab_pkg;

    // fixed field widths
    localparam int COORD_W = 16;
    localparam int DIFF_W  = 17;
    localparam int OUT_W   = 16;

    // defaults for the top-level parameters
    localparam int DEF_CORDIC_STEPS    = 14;
    localparam int DEF_ANGLE_FRAC_BITS = 7;

    // cordic datapath: vector prescaled by 2^8, angle in 2^-16 degree
    localparam int PRESCALE_SH = 8;
    localparam int ACC_FRAC    = 16;
    localparam int TABLE_LEN   = 24;
    localparam int XW          = 28;
    localparam int ZW          = 25;
    localparam int ZC_W        = 23;
    localparam logic [ZC_W-1:0] Z_MAX = ZC_W'(90 << ACC_FRAC);

    // per-item side info carried next to the cordic vector
    typedef struct packed {
        logic ax_zero;
        logic az_zero;
        logic x_lt;
        logic x_gt;
        logic z_lt;
        logic z_gt;
    } t_side;

    // atan(2^-i) in units of 2^-16 degree, rounded to nearest
    function automatic logic [ZW-1:0] atan_deg(input int unsigned idx);
        logic [ZW-1:0] v;
        case (idx)
            0:       v = ZW'(2949120);
            1:       v = ZW'(1740967);
            2:       v = ZW'(919879);
            3:       v = ZW'(466945);
            4:       v = ZW'(234379);
            5:       v = ZW'(117304);
            6:       v = ZW'(58666);
            7:       v = ZW'(29335);
            8:       v = ZW'(14668);
            9:       v = ZW'(7334);
            10:      v = ZW'(3667);
            11:      v = ZW'(1833);
            12:      v = ZW'(917);
            13:      v = ZW'(458);
            14:      v = ZW'(229);
            15:      v = ZW'(115);
            16:      v = ZW'(57);
            17:      v = ZW'(29);
            18:      v = ZW'(14);
            19:      v = ZW'(7);
            20:      v = ZW'(4);
            21:      v = ZW'(2);
            22:      v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/hab_cordic_stage.sv */
module hab_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [hab_pkg::XW-1:0] i_x,
    input  logic signed [hab_pkg::XW-1:0] i_y,
    input  logic signed [hab_pkg::ZW-1:0] i_z,
    input  hab_pkg::t_side            i_side,
    output logic                      o_valid,
    output logic signed [hab_pkg::XW-1:0] o_x,
    output logic signed [hab_pkg::XW-1:0] o_y,
    output logic signed [hab_pkg::ZW-1:0] o_z,
    output hab_pkg::t_side            o_side
);
    import hab_pkg::*;

    localparam logic signed [ZW-1:0] TAB = $signed(atan_deg(STEP));

    logic signed [XW-1:0] c_dx;
    logic signed [XW-1:0] c_dy;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic signed [ZW-1:0] n_z;

    // one vectoring micro-rotation, direction from the sign of y
    always_comb begin
        c_dx = i_y >>> STEP;
        c_dy = i_x >>> STEP;
        if (!i_y[XW-1]) begin
            n_x = i_x + c_dx;
            n_y = i_y - c_dy;
            n_z = i_z + TAB;
        end else begin
            n_x = i_x - c_dx;
            n_y = i_y + c_dy;
            n_z = i_z - TAB;
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x    <= n_x;
            o_y    <= n_y;
            o_z    <= n_z;
            o_side <= i_side;
        end
    end

endmodule

/* hdl/heading_angle_between_points.sv */
// heading from a first planar point to a second, in degrees
// input channel: i_in_valid / o_in_ready, one beat carries both points
//   (x and z, signed, units of 1/16)
// output channel: o_out_valid / i_out_ready, one beat carries
//   o_heading_deg, signed, units of 2^-ANGLE_FRAC_BITS degree
// stages: one difference stage, one stage per cordic micro-rotation,
//   a clamp/round stage and the quadrant mapping stage that feeds the
//   output register
// throughput: one pair per cycle while not stalled; every stage holds
//   one item, so the rate is set by the unrolled micro-rotation chain
// stall: each stage advances when the one after it is empty or moving,
//   so while the receiver holds off, bubbles still fill and new pairs
//   are taken until the pipe is full; nothing is dropped or repeated
// reset: synchronous, active low; clears every stage valid bit, the
//   block accepts a pair in the first cycle after reset
module heading_angle_between_points #(
    parameter int CORDIC_STEPS    = hab_pkg::DEF_CORDIC_STEPS,
    parameter int ANGLE_FRAC_BITS = hab_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [hab_pkg::COORD_W-1:0] i_first_x,
    input  logic signed [hab_pkg::COORD_W-1:0] i_first_z,
    input  logic signed [hab_pkg::COORD_W-1:0] i_second_x,
    input  logic signed [hab_pkg::COORD_W-1:0] i_second_z,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [hab_pkg::OUT_W-1:0]   o_heading_deg
);
    import hab_pkg::*;

    localparam int N   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int NST = N + 3;
    localparam int SH  = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int AW  = ANGLE_FRAC_BITS + 7;
    localparam int RW  = (ANGLE_FRAC_BITS + 10 > OUT_W) ? ANGLE_FRAC_BITS + 10 : OUT_W + 1;
    localparam logic [ZC_W:0]   HALF   = (ZC_W + 1)'(1 << (SH - 1));
    localparam logic signed [RW-1:0] ONE80  = RW'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [RW-1:0] NINETY = RW'(90 << ANGLE_FRAC_BITS);

    // stage valid bits and advance enables
    logic [NST-1:0] c_v;
    logic [NST-1:0] c_en;

    // cordic vector per stage, index 0 is the difference stage
    logic signed [XW-1:0] c_x [0:N];
    logic signed [XW-1:0] c_y [0:N];
    logic signed [ZW-1:0] c_z [0:N];
    t_side                c_side [0:N];
    logic [N:0]           c_cv;

    // difference stage
    logic signed [DIFF_W-1:0] c_dx;
    logic signed [DIFF_W-1:0] c_dz;
    logic [DIFF_W-1:0]        c_ax;
    logic [DIFF_W-1:0]        c_az;
    logic                     r_v0;
    logic signed [XW-1:0]     r_x0;
    logic signed [XW-1:0]     r_y0;
    t_side                    r_side0;
    t_side                    n_side0;

    // round stage
    logic                     r_vr;
    logic [AW-1:0]            r_alpha;
    t_side                    r_sider;
    logic [ZC_W-1:0]          n_zc;
    logic [ZC_W:0]            n_sum;
    logic [AW-1:0]            n_alpha;

    // mapping stage
    logic signed [RW-1:0]     n_res;
    logic signed [RW-1:0]     c_alpha_s;
    logic signed [RW-1:0]     c_base;
    logic signed [OUT_W-1:0]  r_heading;
    logic                     r_out_valid;

    // stall chain: a stage moves when empty or when its successor moves
    always_comb begin
        c_v[0] = r_v0;
        for (int k = 1; k <= N; k++) begin
            c_v[k] = c_cv[k];
        end
        c_v[N+1] = r_vr;
        c_v[N+2] = r_out_valid;
        c_en[NST-1] = !c_v[NST-1] || i_out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            c_en[k] = !c_v[k] || c_en[k+1];
        end
    end

    assign o_in_ready = c_en[0];

    // differences, magnitudes and quadrant flags
    always_comb begin
        c_dx = DIFF_W'(i_first_x) - DIFF_W'(i_second_x);
        c_dz = DIFF_W'(i_first_z) - DIFF_W'(i_second_z);
        c_ax = c_dx[DIFF_W-1] ? DIFF_W'(-c_dx) : DIFF_W'(c_dx);
        c_az = c_dz[DIFF_W-1] ? DIFF_W'(-c_dz) : DIFF_W'(c_dz);
        n_side0.ax_zero = (c_dx == '0);
        n_side0.az_zero = (c_dz == '0);
        n_side0.x_lt    = c_dx[DIFF_W-1];
        n_side0.x_gt    = !c_dx[DIFF_W-1] && (c_dx != '0);
        n_side0.z_lt    = c_dz[DIFF_W-1];
        n_side0.z_gt    = !c_dz[DIFF_W-1] && (c_dz != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (c_en[0]) begin
            r_v0 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en[0]) begin
            r_x0    <= $signed(XW'({c_ax, {PRESCALE_SH{1'b0}}}));
            r_y0    <= $signed(XW'({c_az, {PRESCALE_SH{1'b0}}}));
            r_side0 <= n_side0;
        end
    end

    assign c_x[0]    = r_x0;
    assign c_y[0]    = r_y0;
    assign c_z[0]    = '0;
    assign c_side[0] = r_side0;
    assign c_cv[0]   = r_v0;

    // unrolled micro-rotations
    for (genvar g = 0; g < N; g++) begin : g_cordic
        hab_cordic_stage #(
            .STEP(g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (c_en[g+1]),
            .i_valid (c_cv[g]),
            .i_x     (c_x[g]),
            .i_y     (c_y[g]),
            .i_z     (c_z[g]),
            .i_side  (c_side[g]),
            .o_valid (c_cv[g+1]),
            .o_x     (c_x[g+1]),
            .o_y     (c_y[g+1]),
            .o_z     (c_z[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    // clamp to 0..90 degrees and round half up
    always_comb begin
        if (c_z[N][ZW-1]) begin
            n_zc = '0;
        end else if (ZC_W'(c_z[N]) > Z_MAX || c_z[N][ZW-2:ZC_W] != '0) begin
            n_zc = Z_MAX;
        end else begin
            n_zc = ZC_W'(c_z[N]);
        end
        n_sum   = (ZC_W + 1)'(n_zc) + HALF;
        n_alpha = AW'(n_sum >> SH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr <= 1'b0;
        end else if (c_en[N+1]) begin
            r_vr <= c_cv[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en[N+1]) begin
            r_alpha <= n_alpha;
            r_sider <= c_side[N];
        end
    end

    // quadrant mapping and the -90 offset; a zero x difference maps straight along z
    always_comb begin
        c_alpha_s = $signed(RW'(r_alpha));
        if (r_sider.az_zero) begin
            c_base = r_sider.x_lt ? '0 : ONE80;
        end else if (r_sider.x_gt && r_sider.z_lt) begin
            c_base = c_alpha_s + ONE80;
        end else if (r_sider.x_lt && r_sider.z_lt) begin
            c_base = -c_alpha_s;
        end else if (r_sider.x_gt && r_sider.z_gt) begin
            c_base = ONE80 - c_alpha_s;
        end else begin
            c_base = c_alpha_s;
        end
        if (r_sider.ax_zero) begin
            n_res = r_sider.z_lt ? ONE80 : '0;
        end else begin
            n_res = c_base - NINETY;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_en[N+2]) begin
            r_out_valid <= r_vr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en[N+2]) begin
            r_heading <= n_res[OUT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_heading_deg = r_heading;

endmodule

/* hdl/hab_checker.sv */
module hab_checker #(
    parameter int ANGLE_FRAC_BITS = hab_pkg::DEF_ANGLE_FRAC_BITS
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic signed [hab_pkg::OUT_W-1:0]  o_heading_deg
);
    import hab_pkg::*;

    localparam bit IN_RANGE_CHECK = (ANGLE_FRAC_BITS + 9 <= OUT_W);
    localparam logic signed [OUT_W-1:0] LIM = OUT_W'(180 << ANGLE_FRAC_BITS);

    // a held result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // with the output register empty the whole pipe can move
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input held off with an empty output");

    // heading stays within -180..180 degrees, checked only when +-180 degrees fits in OUT_W
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && IN_RANGE_CHECK |-> o_heading_deg >= -LIM && o_heading_deg <= LIM)
        else $error("heading out of range");

endmodule

bind heading_angle_between_points hab_checker #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
) u_hab_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_heading_deg (o_heading_deg)
);

/* bench/heading_angle_between_points_tb.sv */
module heading_angle_between_points_tb;

    import hab_pkg::*;

    localparam int  STEPS      = DEF_CORDIC_STEPS;
    localparam int  FRAC       = DEF_ANGLE_FRAC_BITS;
    localparam int  ATAN_LEN   = 24;
    localparam int  LATENCY    = STEPS + 3;
    localparam int  N_RANDOM   = 1100;
    localparam longint CYCLE_LIMIT = 400000;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    localparam longint ATAN_DEG_Q16 [ATAN_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [OUT_W-1:0]   t_heading;

    // heading predictor and queue of headings still to come out
    class heading_checker;
        t_heading pending_headings[$];
        int       failures;

        function new();
            failures = 0;
        endfunction

        // base angle atan(b/a) in degrees by cordic vectoring, a > 0, b >= 0
        function longint cordic_atan_deg(longint a, longint b);
            longint vx, vy, ang, step_x, step_y;
            int     i;
            vx  = a * 256;
            vy  = b * 256;
            ang = 0;
            for (i = 0; i < STEPS && i < ATAN_LEN; i++) begin
                step_x = vy >>> i;
                step_y = vx >>> i;
                if (vy >= 0) begin
                    vx  = vx + step_x;
                    vy  = vy - step_y;
                    ang = ang + ATAN_DEG_Q16[i];
                end else begin
                    vx  = vx - step_x;
                    vy  = vy + step_y;
                    ang = ang - ATAN_DEG_Q16[i];
                end
            end
            if (ang < 0)
                ang = 0;
            if (ang > (longint'(90) << ACC_FRAC))
                ang = longint'(90) << ACC_FRAC;
            return (ang + (longint'(1) << (ACC_FRAC - FRAC - 1))) >>> (ACC_FRAC - FRAC);
        endfunction

        function t_heading predict_heading(t_coord fx, t_coord fz, t_coord sx, t_coord sz);
            longint x1, z1, x2, z2, ax, az, deg180, deg90, alpha, res;
            x1 = longint'(fx);
            z1 = longint'(fz);
            x2 = longint'(sx);
            z2 = longint'(sz);
            ax = (x1 > x2) ? x1 - x2 : x2 - x1;
            az = (z1 > z2) ? z1 - z2 : z2 - z1;
            deg180 = longint'(180) << FRAC;
            deg90  = longint'(90) << FRAC;
            if (ax != 0) begin
                if (az == 0) begin
                    alpha = (x1 < x2) ? 0 : deg180;
                end else begin
                    alpha = cordic_atan_deg(ax, az);
                    if (x1 > x2 && z1 < z2)
                        alpha = alpha + deg180;
                    else if (x1 < x2 && z1 < z2)
                        alpha = -alpha;
                    else if (x1 > x2 && z1 > z2)
                        alpha = deg180 - alpha;
                end
                res = alpha - deg90;
            end else begin
                // same x: straight along z, no offset
                res = (z1 < z2) ? deg180 : 0;
            end
            return t_heading'(res);
        endfunction

        function void note_points(t_coord fx, t_coord fz, t_coord sx, t_coord sz);
            pending_headings.push_back(predict_heading(fx, fz, sx, sz));
        endfunction

        function void check_heading(t_heading got);
            t_heading want;
            if (pending_headings.size() == 0) begin
                $error("heading_deg: expected none, actual %0d", got);
                failures++;
            end else begin
                want = pending_headings.pop_front();
                if (got !== want) begin
                    $error("heading_deg: expected %0d, actual %0d", want, got);
                    failures++;
                end
            end
        endfunction

        function void check_drained();
            if (pending_headings.size() != 0) begin
                $error("heading_deg: %0d expected beats never arrived",
                       pending_headings.size());
                failures++;
            end
        endfunction
    endclass

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     i_out_ready = 1'b0;
    t_coord   i_first_x   = '0;
    t_coord   i_first_z   = '0;
    t_coord   i_second_x  = '0;
    t_coord   i_second_z  = '0;
    logic     o_in_ready;
    logic     o_out_valid;
    t_heading o_heading_deg;

    heading_checker chk = new();
    longint         cycles = 0;
    logic           no_idle = 1'b0;

    heading_angle_between_points i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_first_x     (i_first_x),
        .i_first_z     (i_first_z),
        .i_second_x    (i_second_x),
        .i_second_z    (i_second_z),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_heading_deg (o_heading_deg)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("heading_angle_between_points_tb failed");
            $finish;
        end
    end

    // input beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            chk.note_points(i_first_x, i_first_z, i_second_x, i_second_z);
    end

    // output beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            chk.check_heading(o_heading_deg);
    end

    // drive one point pair after a random gap, hold until accepted
    task automatic send_points(t_coord fx, t_coord fz, t_coord sx, t_coord sz);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_first_x  <= fx;
        i_first_z  <= fz;
        i_second_x <= sx;
        i_second_z <= sz;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic t_coord corner_coord();
        case ($urandom_range(0, 4))
            0:       return t_coord'(-32768);
            1:       return t_coord'(-1);
            2:       return t_coord'(0);
            3:       return t_coord'(1);
            default: return t_coord'(32767);
        endcase
    endfunction

    // random pair: mostly full range, some close pairs, shared axes and corners
    task automatic send_random_points();
        t_coord fx, fz, sx, sz;
        int     kind;
        kind = $urandom_range(0, 9);
        fx = t_coord'($urandom());
        fz = t_coord'($urandom());
        sx = t_coord'($urandom());
        sz = t_coord'($urandom());
        case (kind)
            5, 6: begin
                sx = t_coord'(fx + $urandom_range(0, 64) - 32);
                sz = t_coord'(fz + $urandom_range(0, 64) - 32);
            end
            7: begin
                sx = fx;
                if ($urandom_range(0, 3) == 0)
                    sz = fz;
            end
            8: sz = fz;
            9: begin
                fx = corner_coord();
                fz = corner_coord();
                sx = corner_coord();
                sz = corner_coord();
            end
            default: ;
        endcase
        send_points(fx, fz, sx, sz);
    endtask

    // output side: random stall before each beat
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // stimulus and end of run
    initial begin
        int n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners, shared axes, each quadrant, steep and shallow
        send_points(-32768, -32768, 32767, 32767);
        send_points(32767, 32767, -32768, -32768);
        send_points(-32768, 32767, 32767, -32768);
        send_points(32767, -32768, -32768, 32767);
        send_points(0, 0, 0, 0);
        send_points(-32768, -32768, -32768, -32768);
        send_points(100, -5, 100, 7);
        send_points(100, 7, 100, -5);
        send_points(32767, -32768, 32767, 32767);
        send_points(-3, 40, 9, 40);
        send_points(9, 40, -3, 40);
        send_points(-32768, 0, 32767, 0);
        send_points(32767, 0, -32768, 0);
        send_points(5, 3, 0, 0);
        send_points(0, 0, 5, 3);
        send_points(5, 0, 0, 3);
        send_points(0, 3, 5, 0);
        send_points(-32768, 0, 32767, 1);
        send_points(32767, 1, -32768, 0);
        send_points(0, -32768, 1, 32767);
        send_points(1, 32767, 0, -32768);
        send_points(0, 0, 1, 1);
        send_points(1, 1, 0, 0);
        send_points(-16, 12, 7, -20);

        // random pairs with idle-free stretches now and then
        for (n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0)
                no_idle <= ($urandom_range(0, 2) == 0);
            send_random_points();
        end
        i_in_valid <= 1'b0;
        no_idle    <= 1'b0;

        // drain, then watch a little longer for stray beats
        while (chk.pending_headings.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        chk.check_drained();
        if (chk.failures == 0)
            $display("heading_angle_between_points_tb passed");
        else
            $display("heading_angle_between_points_tb failed");
        $finish;
    end

endmodule

/* sim.f */
hdl/hab_pkg.sv
hdl/hab_cordic_stage.sv
hdl/heading_angle_between_points.sv
hdl/hab_checker.sv
bench/heading_angle_between_points_tb.sv
